@@ rtl/core/lbb_pkg.sv @@
// lbb_pkg: shared constants, register indexes and types of the led animator
// depends on nothing; used by the interfaces, the shared adder and the top level
package lbb_pkg;

    localparam int LED_COUNT_DEF = 5;
    localparam int OUT_FIELDS    = 5;
    localparam int NOW_W         = 32;
    localparam int LEVEL_W       = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_ON    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_OFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING     = 3'd7;

    // register reset values
    localparam logic [9:0]  RST_MODE        = 10'd0;
    localparam logic [19:0] RST_PULSE_COUNT = 20'h11111;
    localparam logic [15:0] RST_PULSE_ON    = 16'd50;
    localparam logic [15:0] RST_PULSE_OFF   = 16'd150;
    localparam logic [15:0] RST_PERIOD      = 16'd2000;
    localparam logic [15:0] RST_FRAME       = 16'd10;
    localparam logic [7:0]  RST_FLOOR       = 8'd10;
    localparam logic [7:0]  RST_CEILING     = 8'd125;

    // led modes
    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_ON      = 2'd1;
    localparam logic [1:0] MODE_BLINK   = 2'd2;
    localparam logic [1:0] MODE_BREATHE = 2'd3;

    // breathing direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // shared adder request and response
    typedef struct packed {
        logic             sub;
        logic [NOW_W-1:0] a;
        logic [NOW_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [NOW_W-1:0] y;
        logic             borrow;
    } alu_rsp_t;

endpackage

@@ rtl/core/lbb_in_if.sv @@
// lbb_in_if: update channel, one beat per millisecond tick carrying now_ms
// depends on lbb_pkg
interface lbb_in_if;
    logic                       valid;
    logic                       ready;
    logic [lbb_pkg::NOW_W-1:0]  now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

@@ rtl/core/lbb_out_if.sv @@
// lbb_out_if: level channel, one beat with the level of every led
// depends on lbb_pkg
interface lbb_out_if;
    logic                         valid;
    logic                         ready;
    logic [lbb_pkg::LEVEL_W-1:0]  level_led0;
    logic [lbb_pkg::LEVEL_W-1:0]  level_led1;
    logic [lbb_pkg::LEVEL_W-1:0]  level_led2;
    logic [lbb_pkg::LEVEL_W-1:0]  level_led3;
    logic [lbb_pkg::LEVEL_W-1:0]  level_led4;

    modport source (output valid, output level_led0, output level_led1, output level_led2,
                    output level_led3, output level_led4, input ready);
    modport sink   (input valid, input level_led0, input level_led1, input level_led2,
                    input level_led3, input level_led4, output ready);
endinterface

@@ rtl/core/lbb_alu.sv @@
// lbb_alu: shared 32-bit add / subtract unit with borrow out
// depends on lbb_pkg
module lbb_alu
(
    input  lbb_pkg::alu_req_t req,
    output lbb_pkg::alu_rsp_t rsp
);

    logic [lbb_pkg::NOW_W:0] sum;

    always_comb
    begin
        if (req.sub)
        begin
            sum = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            sum = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.y      = sum[lbb_pkg::NOW_W-1:0];
        rsp.borrow = sum[lbb_pkg::NOW_W];
    end

endmodule

@@ rtl/core/led_blink_breathe_animator.sv @@
// led_blink_breathe_animator: per-led off / on / blink / breathe level sequencer
// depends on lbb_pkg, lbb_in_if, lbb_out_if and lbb_alu

// Each update beat carries the current time in milliseconds. The block walks
// the leds one after another through a small sequencer that drives a single
// shared 32-bit add / subtract unit, so the next beat is held off (update.ready
// low) until every led has been served. Per led the walk takes the elapsed time
// step alone for off and on, that step and the frame compare for breathe, and
// for blink the elapsed time, period compare, on plus off, a 4 x 17 multiply,
// then the on-end and off-end sums and compares, stopping once the level is
// known. The finished levels sit in an output register, so a new update is
// taken while the previous level beat still waits for its sink. Configuration
// writes must be made only while the block is idle; the block itself does not
// enforce it. Leds whose mode or count bits lie beyond the register width stay
// off, and level fields for leds that do not exist read zero.
module led_blink_breathe_animator
#(
    parameter int LED_COUNT = lbb_pkg::LED_COUNT_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    lbb_in_if.sink                          update,
    lbb_out_if.source                       levels
);

    localparam int LW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ELAP   = 4'd1;
    localparam logic [3:0] ST_CMP    = 4'd2;
    localparam logic [3:0] ST_SUM    = 4'd3;
    localparam logic [3:0] ST_MUL    = 4'd4;
    localparam logic [3:0] ST_ONEND  = 4'd5;
    localparam logic [3:0] ST_CMPON  = 4'd6;
    localparam logic [3:0] ST_OFFEND = 4'd7;
    localparam logic [3:0] ST_CMPOFF = 4'd8;
    localparam logic [3:0] ST_BCMP   = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    // configuration registers
    logic [9:0]  mode_reg;
    logic [19:0] count_reg;
    logic [15:0] on_reg;
    logic [15:0] off_reg;
    logic [15:0] period_reg;
    logic [15:0] frame_reg;
    logic [7:0]  floor_reg;
    logic [7:0]  ceiling_reg;

    // per led state
    logic [31:0] ps_reg  [LED_COUNT];
    logic [3:0]  idx_reg [LED_COUNT];
    logic [7:0]  lvl_reg [LED_COUNT];
    logic [1:0]  dir_reg [LED_COUNT];

    // sequencer and work registers
    logic [3:0]    state_reg, state_next;
    logic [LW-1:0] led_reg, led_next;
    logic [31:0]   now_reg;
    logic [31:0]   elap_reg;
    logic [16:0]   sum_reg;
    logic [20:0]   prod_reg;
    logic [20:0]   bound_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_lvl_reg [lbb_pkg::OUT_FIELDS];
    logic [7:0] snap_lvl    [lbb_pkg::OUT_FIELDS];

    // per led write strobes
    logic        wr_ps, wr_idx, wr_lvl, wr_dir;
    logic [31:0] ps_new;
    logic [3:0]  idx_new;
    logic [7:0]  lvl_new;
    logic [1:0]  dir_new;

    // work register loads
    logic ld_elap, ld_sum, ld_prod, ld_bound;

    lbb_pkg::alu_req_t alu_req;
    lbb_pkg::alu_rsp_t alu_rsp;

    lbb_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // mode and pulse count of the led in hand, zero beyond the register width
    logic [31:0] mode_ext;
    logic [63:0] count_ext;
    logic [1:0]  mode_cur;
    logic [3:0]  count_cur;
    logic [7:0]  lvl_step;
    logic        last_led;

    assign mode_ext  = 32'(mode_reg) >> {led_reg, 1'b0};
    assign count_ext = 64'(count_reg) >> {led_reg, 2'b00};
    assign mode_cur  = mode_ext[1:0];
    assign count_cur = count_ext[3:0];
    assign last_led  = (led_reg == LW'(LED_COUNT - 1));

    // saturating breathing step
    always_comb
    begin
        lvl_step = lvl_reg[led_reg];
        case (dir_reg[led_reg])
            lbb_pkg::DIR_UP:
            begin
                if (lvl_reg[led_reg] != 8'hff)
                begin
                    lvl_step = lvl_reg[led_reg] + 8'd1;
                end
            end
            lbb_pkg::DIR_DOWN:
            begin
                if (lvl_reg[led_reg] != 8'h00)
                begin
                    lvl_step = lvl_reg[led_reg] - 8'd1;
                end
            end
            default:
            begin
                lvl_step = lvl_reg[led_reg];
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        led_next    = led_reg;
        alu_req.sub = 1'b1;
        alu_req.a   = elap_reg;
        alu_req.b   = 32'(bound_reg);
        wr_ps       = 1'b0;
        wr_idx      = 1'b0;
        wr_lvl      = 1'b0;
        wr_dir      = 1'b0;
        ps_new      = now_reg;
        idx_new     = idx_reg[led_reg];
        lvl_new     = lvl_reg[led_reg];
        dir_new     = dir_reg[led_reg];
        ld_elap     = 1'b0;
        ld_sum      = 1'b0;
        ld_prod     = 1'b0;
        ld_bound    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (update.valid)
                begin
                    led_next   = '0;
                    state_next = ST_ELAP;
                end
            end
            ST_ELAP:
            begin
                alu_req.a = now_reg;
                alu_req.b = ps_reg[led_reg];
                ld_elap   = 1'b1;
                case (mode_cur)
                    lbb_pkg::MODE_OFF:
                    begin
                        wr_lvl  = 1'b1;
                        lvl_new = 8'd0;
                    end
                    lbb_pkg::MODE_ON:
                    begin
                        wr_lvl  = 1'b1;
                        lvl_new = 8'd1;
                    end
                    lbb_pkg::MODE_BLINK:
                    begin
                        state_next = ST_CMP;
                    end
                    default:
                    begin
                        state_next = ST_BCMP;
                    end
                endcase
                // off and on finish here
                if (mode_cur == lbb_pkg::MODE_OFF || mode_cur == lbb_pkg::MODE_ON)
                begin
                    if (last_led)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        led_next   = led_reg + LW'(1);
                        state_next = ST_ELAP;
                    end
                end
            end
            ST_CMP:
            begin
                alu_req.a = elap_reg;
                alu_req.b = 32'(period_reg);
                if (!alu_rsp.borrow)
                begin
                    // period over: restart the burst
                    wr_lvl  = 1'b1;
                    lvl_new = 8'd0;
                    wr_ps   = 1'b1;
                    wr_idx  = 1'b1;
                    idx_new = 4'd0;
                end
                else if (idx_reg[led_reg] >= count_cur)
                begin
                    wr_lvl  = 1'b1;
                    lvl_new = 8'd0;
                end
                if (!alu_rsp.borrow || idx_reg[led_reg] >= count_cur)
                begin
                    if (last_led)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        led_next   = led_reg + LW'(1);
                        state_next = ST_ELAP;
                    end
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                alu_req.sub = 1'b0;
                alu_req.a   = 32'(on_reg);
                alu_req.b   = 32'(off_reg);
                ld_sum      = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                ld_prod    = 1'b1;
                state_next = ST_ONEND;
            end
            ST_ONEND:
            begin
                alu_req.sub = 1'b0;
                alu_req.a   = 32'(prod_reg);
                alu_req.b   = 32'(on_reg);
                ld_bound    = 1'b1;
                state_next  = ST_CMPON;
            end
            ST_CMPON:
            begin
                alu_req.a = elap_reg;
                alu_req.b = 32'(bound_reg);
                if (alu_rsp.borrow)
                begin
                    wr_lvl  = 1'b1;
                    lvl_new = 8'd1;
                    if (last_led)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        led_next   = led_reg + LW'(1);
                        state_next = ST_ELAP;
                    end
                end
                else
                begin
                    state_next = ST_OFFEND;
                end
            end
            ST_OFFEND:
            begin
                alu_req.sub = 1'b0;
                alu_req.a   = 32'(prod_reg);
                alu_req.b   = 32'(sum_reg);
                ld_bound    = 1'b1;
                state_next  = ST_CMPOFF;
            end
            ST_CMPOFF:
            begin
                alu_req.a = elap_reg;
                alu_req.b = 32'(bound_reg);
                if (alu_rsp.borrow)
                begin
                    wr_lvl  = 1'b1;
                    lvl_new = 8'd0;
                end
                else
                begin
                    // pulse finished, level left as it stands
                    wr_idx  = 1'b1;
                    idx_new = idx_reg[led_reg] + 4'd1;
                end
                if (last_led)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    led_next   = led_reg + LW'(1);
                    state_next = ST_ELAP;
                end
            end
            ST_BCMP:
            begin
                // borrow set means elapsed is past the frame
                alu_req.a = 32'(frame_reg);
                alu_req.b = elap_reg;
                if (alu_rsp.borrow)
                begin
                    wr_lvl  = 1'b1;
                    lvl_new = lvl_step;
                    wr_ps   = 1'b1;
                    if (lvl_step >= ceiling_reg)
                    begin
                        wr_dir  = 1'b1;
                        dir_new = lbb_pkg::DIR_DOWN;
                    end
                    else if (lvl_step <= floor_reg)
                    begin
                        wr_dir  = 1'b1;
                        dir_new = lbb_pkg::DIR_UP;
                    end
                end
                if (last_led)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    led_next   = led_reg + LW'(1);
                    state_next = ST_ELAP;
                end
            end
            ST_OUT:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || levels.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign update.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            led_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            led_reg   <= led_next;
        end
    end

    // work registers, payload only
    always_ff @(posedge clk)
    begin
        if (update.valid && update.ready)
        begin
            now_reg <= update.now_ms;
        end
        if (ld_elap)
        begin
            elap_reg <= alu_rsp.y;
        end
        if (ld_sum)
        begin
            sum_reg <= alu_rsp.y[16:0];
        end
        if (ld_prod)
        begin
            prod_reg <= 21'(idx_reg[led_reg]) * 21'(sum_reg);
        end
        if (ld_bound)
        begin
            bound_reg <= alu_rsp.y[20:0];
        end
    end

    // per led state, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LED_COUNT; i++)
            begin
                ps_reg[i]  <= '0;
                idx_reg[i] <= '0;
                lvl_reg[i] <= '0;
                dir_reg[i] <= lbb_pkg::DIR_NONE;
            end
        end
        else
        begin
            if (wr_ps)
            begin
                ps_reg[led_reg] <= ps_new;
            end
            if (wr_idx)
            begin
                idx_reg[led_reg] <= idx_new;
            end
            if (wr_lvl)
            begin
                lvl_reg[led_reg] <= lvl_new;
            end
            if (wr_dir)
            begin
                dir_reg[led_reg] <= dir_new;
            end
        end
    end

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= lbb_pkg::RST_MODE;
            count_reg   <= lbb_pkg::RST_PULSE_COUNT;
            on_reg      <= lbb_pkg::RST_PULSE_ON;
            off_reg     <= lbb_pkg::RST_PULSE_OFF;
            period_reg  <= lbb_pkg::RST_PERIOD;
            frame_reg   <= lbb_pkg::RST_FRAME;
            floor_reg   <= lbb_pkg::RST_FLOOR;
            ceiling_reg <= lbb_pkg::RST_CEILING;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lbb_pkg::REG_MODE:        mode_reg    <= cfg_wdata[9:0];
                lbb_pkg::REG_PULSE_COUNT: count_reg   <= cfg_wdata[19:0];
                lbb_pkg::REG_PULSE_ON:    on_reg      <= cfg_wdata[15:0];
                lbb_pkg::REG_PULSE_OFF:   off_reg     <= cfg_wdata[15:0];
                lbb_pkg::REG_PERIOD:      period_reg  <= cfg_wdata[15:0];
                lbb_pkg::REG_FRAME:       frame_reg   <= cfg_wdata[15:0];
                lbb_pkg::REG_FLOOR:       floor_reg   <= cfg_wdata[7:0];
                lbb_pkg::REG_CEILING:     ceiling_reg <= cfg_wdata[7:0];
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    // snapshot of the levels, zero for fields without an led
    for (genvar f = 0; f < lbb_pkg::OUT_FIELDS; f++)
    begin : g_snap
        if (f < LED_COUNT)
        begin : g_led
            assign snap_lvl[f] = lvl_reg[f];
        end
        else
        begin : g_none
            assign snap_lvl[f] = 8'd0;
        end
    end

    logic out_load;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || levels.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (levels.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int f = 0; f < lbb_pkg::OUT_FIELDS; f++)
            begin
                out_lvl_reg[f] <= snap_lvl[f];
            end
        end
    end

    assign levels.valid      = out_valid_reg;
    assign levels.level_led0 = out_lvl_reg[0];
    assign levels.level_led1 = out_lvl_reg[1];
    assign levels.level_led2 = out_lvl_reg[2];
    assign levels.level_led3 = out_lvl_reg[3];
    assign levels.level_led4 = out_lvl_reg[4];

`ifndef SYNTH
    // an accepted update always starts the walk at the first led
    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        (update.valid && update.ready) |=> (state_reg == ST_ELAP && led_reg == '0))
        else $error("walk did not start at the first led");

    // the finished walk lands in the output register and frees the input
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && (!out_valid_reg || levels.ready))
        |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("levels not loaded at end of walk");

    // the led counter never runs past the last led while busy
    a_led_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (led_reg <= LW'(LED_COUNT - 1)))
        else $error("led counter out of range");
`endif

endmodule

@@ tb/led_blink_breathe_animator_tb.sv @@
// led_blink_breathe_animator_tb: self-checking bench for the led blink / breathe animator
// depends on lbb_pkg, lbb_in_if, lbb_out_if and the led_blink_breathe_animator rtl
// a level predictor runs beside the block and every level beat is compared field by field
module led_blink_breathe_animator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEDS          = lbb_pkg::LED_COUNT_DEF;
    // settle time after the last owed beat, enough to cover one item in flight
    localparam int SETTLE_CYCLES = 60;
    // watchdog limit on the whole run, with room for long gaps, receiver stalls
    // and the hold-off
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_UPDATES = 148;

    // shadow of the eight registers, fields at their own widths
    typedef struct {
        logic [9:0]  mode;
        logic [19:0] counts;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
        logic [15:0] period_ms;
        logic [15:0] frame_ms;
        logic [7:0]  floor_lvl;
        logic [7:0]  ceil_lvl;
    } anim_cfg_t;

    // one level beat, index i holds level_led<i>
    typedef logic [lbb_pkg::OUT_FIELDS-1:0][lbb_pkg::LEVEL_W-1:0] level_set_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [lbb_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [lbb_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    lbb_in_if  upd ();
    lbb_out_if lvl ();

    led_blink_breathe_animator uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .update    (upd),
        .levels    (lvl)
    );

    // predictor state, one entry per led
    anim_cfg_t   shadow;
    logic [31:0] led_start [LEDS];
    logic [3:0]  led_pulse [LEDS];
    logic [7:0]  led_lvl   [LEDS];
    logic [1:0]  led_dir   [LEDS];

    level_set_t  expected_levels [$];

    // bookkeeping
    int unsigned n_updates;
    int unsigned n_beats;
    int unsigned n_settings;
    int unsigned n_errors;
    int unsigned cycle_count;

    // sender burst control
    int          burst_left;
    bit          steady_sender;

    // receiver stall control: the test only raises a request, the receiver
    // process does its own counting of the hold-off
    bit          hold_req;
    int unsigned hold_len;
    int unsigned hold_left;
    int unsigned rx_cycle;
    int unsigned rx_style;

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // level predictor
    // ------------------------------------------------------------------

    function automatic anim_cfg_t reset_cfg();
        anim_cfg_t c;
        c.mode      = lbb_pkg::RST_MODE;
        c.counts    = lbb_pkg::RST_PULSE_COUNT;
        c.on_ms     = lbb_pkg::RST_PULSE_ON;
        c.off_ms    = lbb_pkg::RST_PULSE_OFF;
        c.period_ms = lbb_pkg::RST_PERIOD;
        c.frame_ms  = lbb_pkg::RST_FRAME;
        c.floor_lvl = lbb_pkg::RST_FLOOR;
        c.ceil_lvl  = lbb_pkg::RST_CEILING;
        return c;
    endfunction

    function automatic void clear_led_state();
        for (int i = 0; i < LEDS; i++)
        begin
            led_start[i] = '0;
            led_pulse[i] = '0;
            led_lvl[i]   = '0;
            led_dir[i]   = lbb_pkg::DIR_NONE;
        end
    endfunction

    // blink: a burst of pulses at the head of each period
    function automatic void blink_step(input int i, input logic [31:0] t_ms);
        logic [31:0] elapsed;
        logic [3:0]  count;
        logic [63:0] idx;
        logic [63:0] on_end;
        logic [63:0] off_end;
        elapsed = t_ms - led_start[i];
        count   = shadow.counts[4*i +: 4];
        idx     = 64'(led_pulse[i]);
        if (elapsed >= 32'(shadow.period_ms))
        begin
            // period over: go dark and restart the burst
            led_lvl[i]   = '0;
            led_start[i] = t_ms;
            led_pulse[i] = '0;
        end
        else if (idx >= 64'(count))
        begin
            // burst finished, or no pulses at all
            led_lvl[i] = '0;
        end
        else
        begin
            on_end  = (idx + 64'd1) * 64'(shadow.on_ms) + idx * 64'(shadow.off_ms);
            off_end = (idx + 64'd1) * (64'(shadow.on_ms) + 64'(shadow.off_ms));
            if (64'(elapsed) < on_end)
                led_lvl[i] = 8'd1;
            else if (64'(elapsed) < off_end)
                led_lvl[i] = '0;
            else
                led_pulse[i] = 4'(idx + 64'd1);   // level left as it was
        end
    endfunction

    // breathe: one step per frame, turning at the floor and the ceiling
    function automatic void breathe_step(input int i, input logic [31:0] t_ms);
        logic [31:0] elapsed;
        int unsigned lv;
        elapsed = t_ms - led_start[i];
        if (elapsed > 32'(shadow.frame_ms))
        begin
            lv = led_lvl[i];
            if (led_dir[i] == lbb_pkg::DIR_UP && lv < 255)
                lv++;
            else if (led_dir[i] == lbb_pkg::DIR_DOWN && lv > 0)
                lv--;
            // ceiling test first, so a floor above the ceiling turns down
            if (lv >= shadow.ceil_lvl)
                led_dir[i] = lbb_pkg::DIR_DOWN;
            else if (lv <= shadow.floor_lvl)
                led_dir[i] = lbb_pkg::DIR_UP;
            led_lvl[i]   = 8'(lv);
            led_start[i] = t_ms;
        end
    endfunction

    function automatic level_set_t predict_levels(input logic [31:0] t_ms);
        level_set_t r;
        r = '0;
        for (int i = 0; i < LEDS; i++)
        begin
            case (shadow.mode[2*i +: 2])
                lbb_pkg::MODE_OFF:   led_lvl[i] = '0;
                lbb_pkg::MODE_ON:    led_lvl[i] = 8'd1;
                lbb_pkg::MODE_BLINK: blink_step(i, t_ms);
                default:             breathe_step(i, t_ms);
            endcase
        end
        for (int i = 0; i < lbb_pkg::OUT_FIELDS; i++)
            r[i] = (i < LEDS) ? led_lvl[i] : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // receiver: random stall pattern chosen per window, plus the long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rx_cycle++;
        if (hold_req)
        begin
            hold_left = hold_len;
            hold_req  = 1'b0;
        end
        if (!rst_n)
        begin
            lvl.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            lvl.ready <= 1'b0;
        end
        else
        begin
            if (rx_cycle % 64 == 0)
                rx_style = $urandom_range(0, 3);
            case (rx_style)
                0:       lvl.ready <= 1'b1;                              // no stalls
                1:       lvl.ready <= 1'($urandom_range(0, 1));          // coin toss
                2:       lvl.ready <= ($urandom_range(0, 3) == 0);       // mostly stalled
                default: lvl.ready <= (rx_cycle % 5 != 0);               // fixed rhythm
            endcase
        end
    end

    // ------------------------------------------------------------------
    // checker: every accepted level beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_levels
        level_set_t got;
        level_set_t want;
        if (rst_n && lvl.valid && lvl.ready)
        begin
            got = {lvl.level_led4, lvl.level_led3, lvl.level_led2,
                   lvl.level_led1, lvl.level_led0};
            n_beats++;
            if (expected_levels.size() == 0)
            begin
                n_errors++;
                $display("%0t ns: level beat with nothing expected, expected none actual %h",
                         $time, got);
            end
            else
            begin
                want = expected_levels.pop_front();
                for (int i = 0; i < lbb_pkg::OUT_FIELDS; i++)
                begin
                    if (got[i] !== want[i])
                    begin
                        n_errors++;
                        $display("%0t ns: level_led%0d expected %0d actual %0d",
                                 $time, i, want[i], got[i]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ns: run stopped after %0d cycles, %0d beats still owed",
                     $time, cycle_count, expected_levels.size());
            $display("led_blink_breathe_animator: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // shared driving tasks
    // ------------------------------------------------------------------

    // offer one update beat; bursts of random length with random gaps between
    task automatic send_update(input logic [31:0] t_ms);
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = 0;
            if (!steady_sender && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 8);
            if (gap > 0)
            begin
                upd.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        upd.valid  <= 1'b1;
        upd.now_ms <= t_ms;
        @(posedge clk);
        while (!upd.ready)
            @(posedge clk);
        // accepted at this edge: the predictor moves on in the same order
        expected_levels.push_back(predict_levels(t_ms));
        n_updates++;
    endtask

    // stop offering, wait for every owed beat, then let the block go quiet
    task automatic wait_drained();
        upd.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write, write enable left high for a following write
    task automatic put_reg(input logic [lbb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lbb_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // write all eight registers; with dirty set the unused upper data bits carry junk
    task automatic program_regs(input anim_cfg_t c, input bit dirty);
        logic [19:0] junk;
        junk = dirty ? 20'($urandom()) : '0;
        put_reg(lbb_pkg::REG_MODE,        {junk[19:10], c.mode});
        put_reg(lbb_pkg::REG_PULSE_COUNT, c.counts);
        put_reg(lbb_pkg::REG_PULSE_ON,    {junk[19:16], c.on_ms});
        put_reg(lbb_pkg::REG_PULSE_OFF,   {junk[19:16], c.off_ms});
        put_reg(lbb_pkg::REG_PERIOD,      {junk[19:16], c.period_ms});
        put_reg(lbb_pkg::REG_FRAME,       {junk[19:16], c.frame_ms});
        put_reg(lbb_pkg::REG_FLOOR,       {junk[19:8],  c.floor_lvl});
        put_reg(lbb_pkg::REG_CEILING,     {junk[19:8],  c.ceil_lvl});
        cfg_we <= 1'b0;
        shadow = c;
        n_settings++;
    endtask

    // random setting for one phase; small timings so bursts and breaths play out
    function automatic anim_cfg_t random_cfg(input int phase);
        anim_cfg_t c;
        case ($urandom_range(0, 5))
            0:       c.mode = 10'h2AA;                     // every led blinking
            1:       c.mode = 10'h3FF;                     // every led breathing
            default: c.mode = 10'($urandom_range(0, 1023));
        endcase
        for (int i = 0; i < LEDS; i++)
            c.counts[4*i +: 4] = ($urandom_range(0, 7) == 0) ? 4'hF : 4'($urandom_range(0, 4));
        c.on_ms     = 16'($urandom_range(0, 8));
        c.off_ms    = 16'($urandom_range(0, 8));
        c.period_ms = 16'($urandom_range(5, 150));
        c.frame_ms  = 16'($urandom_range(0, 4));
        c.floor_lvl = 8'($urandom_range(0, 40));
        c.ceil_lvl  = 8'(c.floor_lvl + $urandom_range(0, 30));
        // a few phases at the ends of the timing ranges
        if (phase == 0)
        begin
            c.on_ms     = 16'hFFFF;
            c.off_ms    = 16'hFFFF;
            c.period_ms = 16'hFFFF;
        end
        else if (phase == 1)
        begin
            c.on_ms     = '0;
            c.off_ms    = '0;
            c.period_ms = '0;
            c.frame_ms  = '0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            c.period_ms = 16'hFFFF;
            c.frame_ms  = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
        end
        // floor above ceiling, or the level extremes
        case ($urandom_range(0, 7))
            0:
            begin
                c.floor_lvl = 8'($urandom_range(30, 255));
                c.ceil_lvl  = 8'($urandom_range(0, 29));
            end
            1:
            begin
                c.floor_lvl = 8'hFF;
                c.ceil_lvl  = 8'hFF;
            end
            2:
            begin
                c.floor_lvl = '0;
                c.ceil_lvl  = '0;
            end
            default: ;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // state out of reset: registers at their reset values, every led dark, then every led on
    task automatic test_reset_state();
        anim_cfg_t c;
        send_update(32'h0000_0000);
        send_update(32'hFFFF_FFFF);
        wait_drained();
        c = reset_cfg();
        c.mode = {lbb_pkg::MODE_ON, lbb_pkg::MODE_ON, lbb_pkg::MODE_ON,
                  lbb_pkg::MODE_ON, lbb_pkg::MODE_ON};
        program_regs(c, 1'b0);
        send_update(32'h0000_0007);
        wait_drained();
    endtask

    // each mode on its own led, one blink led with no pulses at all
    task automatic test_each_mode();
        anim_cfg_t   c;
        logic [31:0] stamps [12];
        stamps = '{0, 1, 2, 4, 5, 7, 9, 11, 13, 20, 21, 22};
        c.mode      = {lbb_pkg::MODE_BLINK, lbb_pkg::MODE_BREATHE, lbb_pkg::MODE_BLINK,
                       lbb_pkg::MODE_ON, lbb_pkg::MODE_OFF};
        c.counts    = 20'h0_0_2_0_0;      // led2 two pulses, led4 none
        c.on_ms     = 16'd2;
        c.off_ms    = 16'd3;
        c.period_ms = 16'd20;
        c.frame_ms  = 16'd1;
        c.floor_lvl = 8'd1;
        c.ceil_lvl  = 8'd3;
        program_regs(c, 1'b0);
        foreach (stamps[k])
            send_update(stamps[k]);
        wait_drained();
    endtask

    // floor set above ceiling, and modes swapped so state carries across
    task automatic test_floor_over_ceiling();
        anim_cfg_t c;
        c = shadow;
        c.mode      = {lbb_pkg::MODE_BREATHE, lbb_pkg::MODE_BLINK, lbb_pkg::MODE_BREATHE,
                       lbb_pkg::MODE_BLINK, lbb_pkg::MODE_BREATHE};
        c.floor_lvl = 8'd200;
        c.ceil_lvl  = 8'd100;
        program_regs(c, 1'b0);
        send_update(32'd30);
        send_update(32'd40);
        send_update(32'd50);
        wait_drained();
    endtask

    // every register at its largest value, then every register but the mode at zero
    task automatic test_register_extremes();
        anim_cfg_t c;
        c.mode      = 10'h3FF;
        c.counts    = 20'hFFFFF;
        c.on_ms     = 16'hFFFF;
        c.off_ms    = 16'hFFFF;
        c.period_ms = 16'hFFFF;
        c.frame_ms  = 16'hFFFF;
        c.floor_lvl = 8'hFF;
        c.ceil_lvl  = 8'hFF;
        program_regs(c, 1'b0);
        send_update(32'hFFFF_FFFF);
        send_update(32'h0000_0000);        // time wraps
        send_update(32'h8000_0000);
        wait_drained();
        c.counts    = '0;
        c.on_ms     = '0;
        c.off_ms    = '0;
        c.period_ms = '0;
        c.frame_ms  = '0;
        c.floor_lvl = '0;
        c.ceil_lvl  = '0;
        c.mode      = {lbb_pkg::MODE_BREATHE, lbb_pkg::MODE_BLINK, lbb_pkg::MODE_BREATHE,
                       lbb_pkg::MODE_BLINK, lbb_pkg::MODE_BREATHE};
        program_regs(c, 1'b0);
        send_update(32'd5);
        send_update(32'd6);
        wait_drained();
    endtask

    // random settings, each followed by a run of mostly rising timestamps
    task automatic test_random_phases();
        anim_cfg_t   c;
        logic [31:0] t_ms;
        int          step_max;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            c = random_cfg(p);
            program_regs(c, (p % 3) == 2);
            steady_sender = (p % 4) == 3;
            step_max = $urandom_range(1, 12);
            // one phase runs straight across the 32-bit wrap
            t_ms = (p == 5) ? 32'hFFFF_FF80 : 32'($urandom());
            for (int k = 0; k < PHASE_UPDATES; k++)
            begin
                if ($urandom_range(0, 63) == 0)
                    t_ms = 32'($urandom());         // occasional jump anywhere
                else
                    t_ms += 32'($urandom_range(0, step_max));
                send_update(t_ms);
            end
            wait_drained();
        end
        steady_sender = 1'b0;
    endtask

    // small groups, each one drained completely before the next goes in
    task automatic test_drain_pauses();
        logic [31:0] t_ms;
        t_ms = 32'($urandom());
        for (int g = 0; g < 5; g++)
        begin
            for (int k = 0; k < 10; k++)
            begin
                t_ms += 32'($urandom_range(0, 6));
                send_update(t_ms);
            end
            wait_drained();
        end
    endtask

    // level sink holds off for a long stretch while updates keep coming,
    // so the output register fills and update.ready has to drop
    task automatic test_output_backpressure();
        anim_cfg_t   c;
        logic [31:0] t_ms;
        c = random_cfg(RANDOM_PHASES);
        c.mode = {lbb_pkg::MODE_BLINK, lbb_pkg::MODE_BREATHE, lbb_pkg::MODE_BLINK,
                  lbb_pkg::MODE_BREATHE, lbb_pkg::MODE_ON};
        program_regs(c, 1'b0);
        hold_len = 400;
        hold_req = 1'b1;
        repeat (2) @(posedge clk);
        steady_sender = 1'b1;
        t_ms = 32'($urandom());
        for (int k = 0; k < 60; k++)
        begin
            t_ms += 32'($urandom_range(0, 4));
            send_update(t_ms);
        end
        steady_sender = 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_wdata  <= '0;
        upd.valid  <= 1'b0;
        upd.now_ms <= '0;
        n_updates     = 0;
        n_beats       = 0;
        n_settings    = 0;
        n_errors      = 0;
        cycle_count   = 0;
        burst_left    = 0;
        steady_sender = 1'b0;
        hold_req      = 1'b0;
        hold_len      = 0;
        hold_left     = 0;
        rx_cycle      = 0;
        rx_style      = 0;
        shadow = reset_cfg();
        clear_led_state();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_each_mode();
        test_floor_over_ceiling();
        test_register_extremes();
        test_random_phases();
        test_drain_pauses();
        test_output_backpressure();

        wait_drained();
        $display("covered %0d update beats and %0d level beats under %0d register settings",
                 n_updates, n_beats, n_settings);
        $display("off, on, blink and breathe modes, time wrap, long sink hold-off, %0d errors",
                 n_errors);
        if (n_errors == 0)
            $display("led_blink_breathe_animator: match");
        else
            $display("led_blink_breathe_animator: mismatch");
        $finish;
    end

endmodule
